// ===== rtl/ses_pkg.sv =====
// Shared constants, types and the arctangent table for the sight angle pipeline.
package ses_pkg;

  localparam int NW = 56;
  localparam int MW = NW - 1;
  localparam int DIV_STEPS = 31;
  localparam int SQ_STEPS = 31;
  localparam int SW = 62;
  localparam int ASIN_ITERATIONS = 32;
  localparam int CW = 34;
  localparam int ASIN_LAT = 1 + DIV_STEPS + 1 + 1 + SQ_STEPS + ASIN_ITERATIONS + 1;
  localparam int PIPE_LAT = ASIN_LAT + 3;

  localparam logic [22:0] RADIUS_RESET = 23'd6371000;
  localparam logic signed [31:0] HALF_PI_Q30 = 32'sd1686629713;
  localparam logic signed [30:0] GROUND_LIMIT = 31'sd335544320;

  typedef struct packed {
    logic bad;
    logic neg;
    logic exact;
  } asin_flags_t;

  function automatic logic [30:0] atan_q30(input int unsigned i);
    logic [30:0] v;
    unique case (i)
      0: v = 31'd843314857;
      1: v = 31'd497837829;
      2: v = 31'd263043837;
      3: v = 31'd133525159;
      4: v = 31'd67021687;
      5: v = 31'd33543516;
      6: v = 31'd16775851;
      7: v = 31'd8388437;
      8: v = 31'd4194283;
      9: v = 31'd2097149;
      31: v = 31'd1;
      default: v = (i < 31) ? (31'd1 << (30 - i)) : 31'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/ses_asin.sv =====
// Pipelined arcsine of num/den: restoring divider, square root, vectoring CORDIC.
module ses_asin import ses_pkg::*; (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [NW-1:0] num,
  input  logic signed [NW-1:0] den,
  output logic signed [31:0]   angle,
  output logic                 bad
);

  logic [MW-1:0]        dr [0:DIV_STEPS];
  logic [MW-1:0]        dd [0:DIV_STEPS];
  logic [DIV_STEPS-1:0] dq [0:DIV_STEPS];
  asin_flags_t          df [0:DIV_STEPS];

  logic [MW-1:0] mag;
  assign mag = num[NW-1] ? MW'(-num) : MW'(num);

  always_ff @(posedge clk) begin
    if (en) begin
      dr[0]     <= mag;
      dd[0]     <= den[MW-1:0];
      dq[0]     <= '0;
      df[0].neg <= num[NW-1];
      df[0].bad <= (den <= 0) || (mag > den[MW-1:0]);
      df[0].exact <= (mag == den[MW-1:0]);
    end
  end

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    logic [MW:0] t;
    logic        ge;
    assign t  = {dr[j], 1'b0};
    assign ge = t >= {1'b0, dd[j]};
    always_ff @(posedge clk) begin
      if (en) begin
        dr[j+1] <= ge ? MW'(t - {1'b0, dd[j]}) : t[MW-1:0];
        dd[j+1] <= dd[j];
        dq[j+1] <= {dq[j][DIV_STEPS-2:0], ge};
        df[j+1] <= df[j];
      end
    end
  end

  logic [30:0]  rq;
  asin_flags_t  rf;
  logic [31:0]  qinc;
  assign qinc = {1'b0, dq[DIV_STEPS]} + 32'd1;

  always_ff @(posedge clk) begin
    if (en) begin
      rq <= df[DIV_STEPS].exact ? (31'd1 << 30) : qinc[31:1];
      rf <= df[DIV_STEPS];
    end
  end

  logic [SW-1:0]       qv   [0:SQ_STEPS];
  logic [SW-1:0]       qres [0:SQ_STEPS];
  logic signed [CW-1:0] qx  [0:SQ_STEPS];
  asin_flags_t         qf   [0:SQ_STEPS];
  logic [61:0]         sq;
  assign sq = 62'(rq) * 62'(rq);

  always_ff @(posedge clk) begin
    if (en) begin
      qv[0]   <= (62'd1 << 60) - sq;
      qres[0] <= '0;
      qx[0]   <= rf.neg ? -CW'(rq) : CW'(rq);
      qf[0]   <= rf;
    end
  end

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
    localparam logic [SW-1:0] BIT = SW'(1) << (60 - 2 * k);
    logic [SW-1:0] s;
    assign s = qres[k] + BIT;
    always_ff @(posedge clk) begin
      if (en) begin
        if (qv[k] >= s) begin
          qv[k+1]   <= qv[k] - s;
          qres[k+1] <= (qres[k] >> 1) + BIT;
        end else begin
          qv[k+1]   <= qv[k];
          qres[k+1] <= qres[k] >> 1;
        end
        qx[k+1] <= qx[k];
        qf[k+1] <= qf[k];
      end
    end
  end

  logic signed [CW-1:0] cx [0:ASIN_ITERATIONS];
  logic signed [CW-1:0] cy [0:ASIN_ITERATIONS];
  logic signed [CW-1:0] cz [0:ASIN_ITERATIONS];
  asin_flags_t          cf [0:ASIN_ITERATIONS];

  assign cx[0] = CW'(qres[SQ_STEPS][30:0]);
  assign cy[0] = qx[SQ_STEPS];
  assign cz[0] = '0;
  assign cf[0] = qf[SQ_STEPS];

  for (genvar i = 0; i < ASIN_ITERATIONS; i++) begin : g_cordic
    localparam logic signed [CW-1:0] ANG = CW'(atan_q30(i));
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    assign dx = cy[i] >>> i;
    assign dy = cx[i] >>> i;
    always_ff @(posedge clk) begin
      if (en) begin
        if (!cy[i][CW-1]) begin
          cx[i+1] <= cx[i] + dx;
          cy[i+1] <= cy[i] - dy;
          cz[i+1] <= cz[i] + ANG;
        end else begin
          cx[i+1] <= cx[i] - dx;
          cy[i+1] <= cy[i] + dy;
          cz[i+1] <= cz[i] - ANG;
        end
        cf[i+1] <= cf[i];
      end
    end
  end

  logic signed [CW-1:0] zf;
  asin_flags_t          ff;
  assign zf = cz[ASIN_ITERATIONS];
  assign ff = cf[ASIN_ITERATIONS];

  always_ff @(posedge clk) begin
    if (en) begin
      bad <= ff.bad;
      if (ff.bad) begin
        angle <= ff.neg ? -HALF_PI_Q30 : HALF_PI_Q30;
      end else if (zf > CW'(HALF_PI_Q30)) begin
        angle <= HALF_PI_Q30;
      end else if (zf < -CW'(HALF_PI_Q30)) begin
        angle <= -HALF_PI_Q30;
      end else begin
        angle <= zf[31:0];
      end
    end
  end

endmodule

// ===== rtl/spherical_earth_sight_angles.sv =====
// Top level: depression angle, grazing angle and ground range on a spherical earth.
//
// Input beats arrive on s_tvalid/s_tready/s_tdata, one target per beat:
// antenna height in 1/16 m and slant range in metres. Each beat yields
// exactly one output beat on m_tvalid/m_tready/m_tdata, with the range
// error flag on m_tuser. Beats leave in the order they came.
// An input beat passes a product stage, a numerator and denominator stage,
// 98 stages in each arcsine lane (an input register, 31 divider steps, a
// rounding step, a square step, 31 square root steps, 32 CORDIC steps and
// a clamp), one ground range multiply and the output register.
// One beat is taken every cycle while s_tready is high.
// The earth radius lives in an APB register at address 0; write it only
// while no beat is in flight.
// Reset clears all valid bits and loads the radius with 6371000 m.
// When the receiver stalls, a skid register catches one more result;
// after that s_tready drops and the whole pipeline holds.
module spherical_earth_sight_angles import ses_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // antenna_height[19:0], slant_range[41:20]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [95:0] m_tdata,   // depression_angle[31:0], grazing_angle[63:32],
                                 // ground_range[93:64]
  output logic        m_tuser    // range_error
);

  logic [22:0] earth_radius;

  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : {9'd0, earth_radius};

  always_ff @(posedge clk) begin
    if (rst) begin
      earth_radius <= RADIUS_RESET;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      earth_radius <= pwdata[22:0];
    end
  end

  logic                en;
  logic                skid_valid;
  logic [PIPE_LAT-1:0] vpipe;

  assign en       = !skid_valid;
  assign s_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe <= '0;
    end else if (en) begin
      vpipe <= {vpipe[PIPE_LAT-2:0], s_tvalid};
    end
  end

  logic [19:0] h;
  logic [21:0] r;
  logic [27:0] rd;
  assign h  = s_tdata[19:0];
  assign r  = s_tdata[41:20];
  assign rd = {1'b0, earth_radius, 4'd0} + 28'(h);

  logic [42:0] p_hre;
  logic [39:0] p_hh;
  logic [43:0] p_rr;
  logic [49:0] p_rd;
  logic [44:0] p_rre;

  always_ff @(posedge clk) begin
    if (en) begin
      p_hre <= 43'(h) * 43'(earth_radius);
      p_hh  <= 40'(h) * 40'(h);
      p_rr  <= 44'(r) * 44'(r);
      p_rd  <= 50'(r) * 50'(rd);
      p_rre <= 45'(r) * 45'(earth_radius);
    end
  end

  logic signed [NW-1:0] common;
  logic signed [NW-1:0] rr8;
  logic signed [NW-1:0] num_d;
  logic signed [NW-1:0] den_d;
  logic signed [NW-1:0] num_g;
  logic signed [NW-1:0] den_g;
  assign common = NW'({p_hre, 5'd0}) + NW'(p_hh);
  assign rr8    = NW'({p_rr, 8'd0});

  always_ff @(posedge clk) begin
    if (en) begin
      num_d <= common + rr8;
      num_g <= common - rr8;
      den_d <= NW'({p_rd, 5'd0});
      den_g <= NW'({p_rre, 9'd0});
    end
  end

  logic signed [31:0] dep;
  logic signed [31:0] graz;
  logic               bad_d;
  logic               bad_g;

  ses_asin u_dep (
    .clk   (clk),
    .en    (en),
    .num   (num_d),
    .den   (den_d),
    .angle (dep),
    .bad   (bad_d)
  );

  ses_asin u_graz (
    .clk   (clk),
    .en    (en),
    .num   (num_g),
    .den   (den_g),
    .angle (graz),
    .bad   (bad_g)
  );

  logic signed [32:0] diff;
  logic signed [56:0] g_prod;
  logic signed [31:0] g_dep;
  logic signed [31:0] g_graz;
  logic               g_bad;
  assign diff = 33'(dep) - 33'(graz);

  always_ff @(posedge clk) begin
    if (en) begin
      g_prod <= 57'(diff) * 57'($signed({1'b0, earth_radius}));
      g_dep  <= dep;
      g_graz <= graz;
      g_bad  <= bad_d | bad_g;
    end
  end

  logic signed [56:0] g_rnd;
  logic signed [30:0] g_sh;
  logic signed [29:0] g_sat;
  logic [95:0]        fin_data;
  logic               fin_valid;
  assign g_rnd = g_prod + 57'sd33554432;
  assign g_sh  = 31'(g_rnd >>> 26);
  assign g_sat = (g_sh > GROUND_LIMIT) ? 30'(GROUND_LIMIT) :
                 (g_sh < -GROUND_LIMIT) ? 30'(-GROUND_LIMIT) : g_sh[29:0];
  assign fin_data  = {2'b00, g_sat, g_graz, g_dep};
  assign fin_valid = vpipe[PIPE_LAT-1];

  logic [95:0] skid_data;
  logic        skid_user;
  logic        take;
  assign take = m_tvalid && m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (take) begin
        m_tdata    <= skid_data;
        m_tuser    <= skid_user;
        skid_valid <= 1'b0;
      end
    end else if (!m_tvalid || take) begin
      m_tvalid <= fin_valid;
      m_tdata  <= fin_data;
      m_tuser  <= g_bad;
    end else if (fin_valid) begin
      skid_data  <= fin_data;
      skid_user  <= g_bad;
      skid_valid <= 1'b1;
    end
  end

endmodule
